[hdl/rotation_matrix_to_quaternion_defines.svh]
// Assertion macros used by the converter module
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// property b must hold in the cycle after a
`define RMQ_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("rmq check failed");

// property b must hold in the same cycle as a
`define RMQ_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("rmq check failed");

`endif

[hdl/rmq_pkg.sv]
package rmq_pkg;
  // axis codes
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_T = 2'd3
  } axis_t;
  // trace test factor
  localparam int TRACE_MUL = 1000;
endpackage

[hdl/rmq_sqrt.sv]
// Pipelined integer square root, two result bits per stage.
module rmq_sqrt #(
  parameter int IN_W = 36
) (
  input  logic                clk,
  input  logic                en,
  input  logic [IN_W-1:0]     radicand,
  output logic [IN_W/2-1:0]   root
);
  localparam int OUT_W = IN_W / 2;
  localparam int NST = (OUT_W + 1) / 2;

  logic [IN_W-1:0]  rem_q [NST+1];
  logic [OUT_W-1:0] res_q [NST+1];

  assign rem_q[0] = radicand;
  assign res_q[0] = '0;

  // each stage decides two root bits (two restoring steps)
  for (genvar g = 0; g < NST; g++) begin : g_st
    logic [IN_W-1:0]  rem_r;
    logic [OUT_W-1:0] res_r;
    logic [IN_W-1:0]  rem_c;
    logic [OUT_W-1:0] res_c;
    logic [IN_W+1:0]  trial;
    always_comb begin
      rem_c = rem_q[g];
      res_c = res_q[g];
      for (int b = 0; b < 2; b++) begin
        if (2 * g + b < OUT_W) begin
          // trial term is (4*root + 1) at the current bit weight
          trial = {2'b0, rem_c} -
            (({2'b0, {(IN_W-OUT_W){1'b0}}, res_c} << 2 | (IN_W+2)'(1))
             << (2 * (OUT_W - 1 - (2 * g + b))));
          res_c = res_c << 1;
          if (!trial[IN_W+1]) begin
            rem_c = trial[IN_W-1:0];
            res_c[0] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_c;
        res_r <= res_c;
      end
    end
    assign rem_q[g+1] = rem_r;
    assign res_q[g+1] = res_r;
  end

  assign root = res_q[NST];
endmodule

[hdl/rmq_divide.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
module rmq_divide #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 18
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);
  logic [NUM_W-1:0] n_q [NUM_W+1];
  logic [DEN_W-1:0] d_q [NUM_W+1];
  logic [DEN_W:0]   r_q [NUM_W+1];

  assign n_q[0] = num;
  assign d_q[0] = den;
  assign r_q[0] = '0;

  // shift in one numerator bit, subtract when possible
  for (genvar g = 0; g < NUM_W; g++) begin : g_st
    logic [DEN_W+1:0] sh;
    logic [DEN_W+1:0] df;
    logic [NUM_W-1:0] n_r;
    logic [DEN_W-1:0] d_r;
    logic [DEN_W:0]   r_r;
    always_comb begin
      sh = {r_q[g], n_q[g][NUM_W-1]};
      df = sh - {2'b0, d_q[g]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_r <= d_q[g];
        if (!df[DEN_W+1]) begin
          r_r <= df[DEN_W:0];
          n_r <= {n_q[g][NUM_W-2:0], 1'b1};
        end else begin
          r_r <= sh[DEN_W:0];
          n_r <= {n_q[g][NUM_W-2:0], 1'b0};
        end
      end
    end
    assign n_q[g+1] = n_r;
    assign d_q[g+1] = d_r;
    assign r_q[g+1] = r_r;
  end

  assign quo = n_q[NUM_W];
endmodule

[hdl/rotation_matrix_to_quaternion.sv]
// Channel | dir | tdata fields (low bit first)              | tuser
// s_axis  | in  | m00 m01 m02 m10 m11 m12 m20 m21 m22 (DW each)| -
// m_axis  | out | quat_w quat_x quat_y quat_z (DW each)        | invalid
//
// One matrix per cycle sustained while m_axis accepts; the pipeline holds 2 input
// stages, the root stages, 1 sign stage, 2*DW+1 divider stages and 1 output register.
// The root and the four division pipelines set the depth.
// Reset (rst, synchronous) clears the valid bits only.
// A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata, // m00..m22
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata, // w,x,y,z
  output logic                    m_axis_tuser  // invalid
);
  import rmq_pkg::*;
  `include "rotation_matrix_to_quaternion_defines.svh"

  localparam int DW  = DATA_WIDTH;
  localparam int F   = DW - 2;
  localparam int RW  = DW + 3;            // radicand width
  localparam int SQW = 2 * ((RW + F + 1) / 2); // even sqrt input width
  localparam int SW  = SQW / 2;           // root width
  localparam int SQL = (SW + 1) / 2;      // sqrt stages
  localparam int NW  = DW + 2;            // numerator magnitude width
  localparam int QW  = NW + F + 1;        // division dividend width
  localparam int DVW = SW + 1;            // 2s width
  localparam int LAT = 2 + SQL + 1 + QW + 1;
  localparam int TDW = ((9 * DW + 7) / 8) * 8;
  localparam int ODW = ((4 * DW + 7) / 8) * 8;

  logic en;
  logic [LAT-1:0] vld;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end
  assign m_axis_tvalid = vld[LAT-1];

  // stage 1: unpack, trace, axis select
  logic signed [DW-1:0] m [9];
  always_comb begin
    for (int i = 0; i < 9; i++) m[i] = s_axis_tdata[i*DW +: DW];
  end

  logic signed [DW+1:0] tr;
  logic signed [DW+12:0] tr_k;
  axis_t ax_c;
  always_comb begin
    tr = (DW+2)'(m[0]) + (DW+2)'(m[4]) + (DW+2)'(m[8]);
    tr_k = (DW+13)'(tr) * (DW+13)'(TRACE_MUL);
    if (tr_k > (DW+13)'(1) <<< F) ax_c = AXIS_T;
    else if (m[4] > m[0]) ax_c = (m[8] > m[4]) ? AXIS_Z : AXIS_Y;
    else ax_c = (m[8] > m[0]) ? AXIS_Z : AXIS_X;
  end

  axis_t ax1;
  logic signed [DW-1:0] m1 [9];
  logic signed [DW+1:0] tr1;
  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= ax_c;
      m1 <= m;
      tr1 <= tr;
    end
  end

  // stage 2: radicand and numerators
  logic signed [RW-1:0] rad_c;
  logic signed [NW-1:0] n0_c, n1_c, n2_c, n3_c;
  always_comb begin
    n0_c = '0; n1_c = '0; n2_c = '0; n3_c = '0;
    unique case (ax1)
      AXIS_T: begin
        rad_c = (RW)'(1) <<< F;
        rad_c = rad_c + RW'(tr1);
        n1_c = NW'(m1[5]) - NW'(m1[7]);
        n2_c = NW'(m1[6]) - NW'(m1[2]);
        n3_c = NW'(m1[1]) - NW'(m1[3]);
      end
      AXIS_X: begin
        rad_c = ((RW)'(1) <<< F) + RW'(m1[0]) - RW'(m1[4]) - RW'(m1[8]);
        n0_c = NW'(m1[5]) - NW'(m1[7]);
        n2_c = NW'(m1[3]) + NW'(m1[1]);
        n3_c = NW'(m1[6]) + NW'(m1[2]);
      end
      AXIS_Y: begin
        rad_c = ((RW)'(1) <<< F) + RW'(m1[4]) - RW'(m1[8]) - RW'(m1[0]);
        n0_c = NW'(m1[6]) - NW'(m1[2]);
        n3_c = NW'(m1[7]) + NW'(m1[5]);
        n1_c = NW'(m1[1]) + NW'(m1[3]);
      end
      default: begin
        rad_c = ((RW)'(1) <<< F) + RW'(m1[8]) - RW'(m1[0]) - RW'(m1[4]);
        n0_c = NW'(m1[1]) - NW'(m1[3]);
        n1_c = NW'(m1[2]) + NW'(m1[6]);
        n2_c = NW'(m1[5]) + NW'(m1[7]);
      end
    endcase
  end

  logic signed [RW-1:0] rad2;
  logic signed [NW-1:0] n2 [4];
  axis_t ax2;
  always_ff @(posedge clk) begin
    if (en) begin
      rad2 <= rad_c;
      n2[0] <= n0_c; n2[1] <= n1_c; n2[2] <= n2_c; n2[3] <= n3_c;
      ax2 <= ax1;
    end
  end

  // square root of rad * 2^F
  logic [SQW-1:0] sq_in;
  logic [SW-1:0]  s_root;
  assign sq_in = rad2[RW-1] ? '0 : SQW'({rad2[RW-2:0], {F{1'b0}}});
  rmq_sqrt #(.IN_W(SQW)) u_sqrt (
    .clk(clk), .en(en), .radicand(sq_in), .root(s_root)
  );

  // side data delayed along the root pipeline
  logic signed [NW-1:0] nd [SQL+1][4];
  axis_t axd [SQL+1];
  logic  badd [SQL+1];
  assign nd[0] = n2;
  assign axd[0] = ax2;
  assign badd[0] = (rad2 <= 0);
  for (genvar g = 0; g < SQL; g++) begin : g_sd
    always_ff @(posedge clk) begin
      if (en) begin
        nd[g+1] <= nd[g];
        axd[g+1] <= axd[g];
        badd[g+1] <= badd[g];
      end
    end
  end

  // stage: signs and magnitudes
  logic rneg;
  assign rneg = (axd[SQL] != AXIS_T) && nd[SQL][0][NW-1];

  logic [QW-1:0] dnum [4];
  logic [DVW-1:0] dden;
  logic negq [4];
  logic [SW:0] half;
  axis_t ax3;
  logic bad3;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        logic [NW-1:0] mag;
        mag = nd[SQL][i][NW-1] ? NW'(-nd[SQL][i]) : NW'(nd[SQL][i]);
        dnum[i] <= QW'({mag, {F{1'b0}}}) + QW'(s_root);
        negq[i] <= nd[SQL][i][NW-1] ^ rneg;
      end
      dden <= {s_root, 1'b0};
      half <= ((SW+1)'(s_root) + 1'b1) >> 1;
      ax3 <= axd[SQL];
      bad3 <= badd[SQL] && (axd[SQL] != AXIS_T);
      // root sign is registered separately in rneg3 below
    end
  end
  logic rneg3;
  always_ff @(posedge clk) if (en) rneg3 <= rneg;

  // dividers
  logic [QW-1:0] quo [4];
  for (genvar g = 0; g < 4; g++) begin : g_dv
    rmq_divide #(.NUM_W(QW), .DEN_W(DVW)) u_div (
      .clk(clk), .en(en), .num(dnum[g]), .den(dden), .quo(quo[g])
    );
  end

  // side data along dividers
  logic [SW:0] hd [QW+1];
  axis_t axq [QW+1];
  logic bq [QW+1];
  logic nq [QW+1][4];
  logic rq [QW+1];
  assign hd[0] = half; assign axq[0] = ax3; assign bq[0] = bad3;
  assign nq[0] = negq; assign rq[0] = rneg3;
  for (genvar g = 0; g < QW; g++) begin : g_qd
    always_ff @(posedge clk) begin
      if (en) begin
        hd[g+1] <= hd[g]; axq[g+1] <= axq[g]; bq[g+1] <= bq[g];
        nq[g+1] <= nq[g]; rq[g+1] <= rq[g];
      end
    end
  end

  // final: place, sign, saturate, zero invalid results
  function automatic logic [DW-1:0] satv(input logic [QW:0] mg, input logic ng);
    logic signed [QW+1:0] v;
    v = ng ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
    if (v > (QW+2)'((1 <<< (DW-1)) - 1)) return {1'b0, {(DW-1){1'b1}}};
    if (v < -$signed((QW+2)'(1) <<< (DW-1))) return {1'b1, {(DW-1){1'b0}}};
    return v[DW-1:0];
  endfunction

  logic [DW-1:0] q_c [4];
  always_comb begin
    for (int i = 0; i < 4; i++) q_c[i] = satv({1'b0, quo[i]}, nq[QW][i]);
    unique case (axq[QW])
      AXIS_T: q_c[0] = satv((QW+1)'(hd[QW]), 1'b0);
      AXIS_X: q_c[1] = satv((QW+1)'(hd[QW]), rq[QW]);
      AXIS_Y: q_c[2] = satv((QW+1)'(hd[QW]), rq[QW]);
      default: q_c[3] = satv((QW+1)'(hd[QW]), rq[QW]);
    endcase
    if (bq[QW]) for (int i = 0; i < 4; i++) q_c[i] = '0;
  end

  logic [DW-1:0] qo [4];
  logic bo;
  always_ff @(posedge clk) begin
    if (en) begin
      qo <= q_c;
      bo <= bq[QW];
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 4; i++) m_axis_tdata[i*DW +: DW] = qo[i];
  end
  assign m_axis_tuser = bo;

  `RMQ_ASSERT_SAME(a_ready, clk, rst, !m_axis_tvalid, s_axis_tready)
  `RMQ_ASSERT_SAME(a_inv_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `RMQ_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
